// File: src/jbct_pkg.sv
// Package for the jet b-content tagger: widths, reciprocal constants and the
// per-constituent b-count decode function.
// No dependencies; used by jet_b_content_tagger_unit.
package jbct_pkg;

  localparam int CODE_W   = 25;
  localparam int MAG_W    = 25;
  localparam int WEIGHT_W = 16;
  localparam int NET_W    = 12;
  localparam int SUM_W    = 12;  // running sum width, legal 4..32
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_PROB  = 1'b0,
    CFG_FAKE_PROB = 1'b1
  } cfg_idx_t;

  // Exact floor division of a 25-bit magnitude by 10000: (x * MUL_10K) >> 39.
  localparam logic [25:0] MUL_10K   = 26'd54975582;
  localparam int          SHIFT_10K = 39;
  localparam logic [13:0] TEN_K     = 14'd10000;

  // Exact floor division of a 14-bit remainder by 10, 100 and 1000.
  localparam logic [14:0] MUL_10   = 15'd26215;   // shift 18
  localparam logic [14:0] MUL_100  = 15'd20972;   // shift 21
  localparam logic [14:0] MUL_1000 = 15'd16778;   // shift 24

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic signed [2:0] contrib;
    logic              bad;
  } decode_t;

  function automatic logic [1:0] is_five(input digit_t d);
    is_five = {1'b0, (d == 4'd5)};
  endfunction

  // Net b count of one code from its four low decimal digits.
  function automatic decode_t decode_b(input digit_t d3, input digit_t d2,
                                       input digit_t d1, input digit_t d0,
                                       input logic is_zero, input logic neg);
    decode_t     res;
    logic [1:0]  cnt;
    logic        flip;
    logic signed [2:0] pos;
    res  = '0;
    cnt  = '0;
    flip = 1'b0;
    pos  = '0;
    if (is_zero) begin
      res = '0;
    end else if (d3 != 4'd0) begin
      // Baryon or diquark: every 5 in the upper three digits counts.
      res.bad = (d3 > 4'd6) || (d2 > 4'd6) || (d1 > 4'd6);
      cnt = is_five(d3) + is_five(d2) + is_five(d1);
      pos = $signed({1'b0, cnt});
      if (!res.bad) begin
        res.contrib = neg ? -pos : pos;
      end
    end else if (d2 != 4'd0) begin
      // Meson: flavor sign flips when the leading digit is 3 or 5.
      res.bad = (d2 > 4'd6) || (d1 > 4'd6);
      flip = (d2 == 4'd3) || (d2 == 4'd5);
      if ((d2 == 4'd5) && (d1 != 4'd5)) begin
        pos = 3'sd1;
      end else if ((d2 != 4'd5) && (d1 == 4'd5)) begin
        pos = -3'sd1;
      end else begin
        pos = 3'sd0;
      end
      if (!res.bad) begin
        res.contrib = (neg ^ flip) ? -pos : pos;
      end
    end else if (d1 != 4'd0) begin
      // Two-digit codes are leptons and carry no b.
      res = '0;
    end else if (d0 != 4'd0) begin
      res.bad = (d0 > 4'd6);
      if (!res.bad && (d0 == 4'd5)) begin
        res.contrib = neg ? -3'sd1 : 3'sd1;
      end
    end else begin
      // Nonzero code whose low four digits are all zero.
      res.bad = 1'b1;
    end
    decode_b = res;
  endfunction

endpackage

// File: src/jet_b_content_tagger_unit.sv
// Top level of the jet b-content tagger: decode pipeline, saturating
// accumulator and result register. Depends on jbct_pkg.
//
// The block takes one jet constituent per transfer and can take one in every
// clock cycle. Each constituent passes through a four-register decode
// pipeline: the input register, a stage that divides the code magnitude by
// 10000 with a reciprocal multiply, a stage that forms the four-digit
// remainder, and a stage that splits that remainder into decimal digits.
// The digits are then decoded into a net b count of -3..3 and added into a
// saturating signed sum in the same cycle. A constituent marked last_in_jet
// loads the result register from the final pipeline stage, and the
// sum and error flag start again from zero for the next jet. The result
// register and the pipeline stages each carry their own valid bit, so input
// keeps flowing while a result waits; only when the final pipeline stage
// holds another end-of-jet constituent and the previous result has not yet
// been taken does the pipeline stall back toward the input. Configuration
// writes take effect on the next cycle and should be made only while no jet
// is in flight, since the weight is picked when the result is formed.
module jet_b_content_tagger_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [jbct_pkg::CODE_W-1:0]   in_particle_code,
  input  logic                                 in_has_identity,
  input  logic                                 in_last_in_jet,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [jbct_pkg::WEIGHT_W-1:0] out_weight,
  output logic                                 out_tagged_res,
  output logic signed [jbct_pkg::NET_W-1:0]    out_net_b_total,
  output logic                                 out_code_error,

  input  logic                                 cfg_we,
  input  logic        [jbct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [jbct_pkg::WEIGHT_W-1:0] cfg_wdata
);

  localparam int SW  = jbct_pkg::SUM_W;
  localparam int MW  = jbct_pkg::MAG_W;

  // Configuration registers.
  logic [jbct_pkg::WEIGHT_W-1:0] tag_prob_r, fake_prob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_prob_r  <= '0;
      fake_prob_r <= '0;
    end else if (cfg_we) begin
      case (jbct_pkg::cfg_idx_t'(cfg_index))
        jbct_pkg::CFG_TAG_PROB:  tag_prob_r  <= cfg_wdata;
        jbct_pkg::CFG_FAKE_PROB: fake_prob_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and the per-stage advance conditions.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_go, s2_go, s3_go, s4_go;
  logic s4_ok, s3_ok, s2_ok, s1_ok;

  // Stage 1: input register.
  logic signed [jbct_pkg::CODE_W-1:0] s1_code_r;
  logic s1_has_r, s1_last_r;

  // Stage 2: quotient by 10000 and low bits of the magnitude.
  logic [11:0] s2_q_r;
  logic [13:0] s2_mag_lo_r;
  logic        s2_zero_r, s2_neg_r, s2_has_r, s2_last_r;

  // Stage 3: magnitude modulo 10000.
  logic [13:0] s3_rem_r;
  logic        s3_zero_r, s3_neg_r, s3_has_r, s3_last_r;

  // Stage 4: decimal digits.
  jbct_pkg::digit_t s4_d3_r, s4_d2_r, s4_d1_r, s4_d0_r;
  logic        s4_zero_r, s4_neg_r, s4_has_r, s4_last_r;

  // Accumulator and result register.
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [jbct_pkg::WEIGHT_W-1:0] out_weight_r;
  logic                 out_tagged_r, out_error_r;
  logic signed [jbct_pkg::NET_W-1:0] out_net_r;

  // A stage moves on unless its successor is full and cannot move. The last
  // stage only blocks when it must write a result into a full result register.
  assign s4_ok = !(s4_v_r && s4_last_r && out_valid_r && !out_ready);
  assign s3_ok = !s4_v_r || s4_ok;
  assign s2_ok = !s3_v_r || s3_ok;
  assign s1_ok = !s2_v_r || s2_ok;
  assign in_ready = !s1_v_r || s1_ok;

  assign s1_go = in_valid && in_ready;
  assign s2_go = s1_v_r && s1_ok;
  assign s3_go = s2_v_r && s2_ok;
  assign s4_go = s3_v_r && s3_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (s1_ok)    s2_v_r <= s1_v_r;
      if (s2_ok)    s3_v_r <= s2_v_r;
      if (s3_ok)    s4_v_r <= s3_v_r;
    end
  end

  // Stage 1 -> 2: magnitude and its quotient by 10000.
  logic [MW-1:0] s1_mag;
  logic [50:0]   prod_10k;

  assign s1_mag   = s1_code_r[jbct_pkg::CODE_W-1] ? MW'(-s1_code_r) : MW'(s1_code_r);
  assign prod_10k = {26'd0, s1_mag} * {25'd0, jbct_pkg::MUL_10K};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_code_r <= in_particle_code;
      s1_has_r  <= in_has_identity;
      s1_last_r <= in_last_in_jet;
    end
    if (s2_go) begin
      s2_q_r      <= prod_10k[jbct_pkg::SHIFT_10K +: 12];
      s2_mag_lo_r <= s1_mag[13:0];
      s2_zero_r   <= (s1_code_r == '0);
      s2_neg_r    <= s1_code_r[jbct_pkg::CODE_W-1];
      s2_has_r    <= s1_has_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // Stage 2 -> 3: the remainder is below 2^14, so arithmetic modulo 2^14 is exact.
  logic [25:0] q_times_10k;

  assign q_times_10k = {14'd0, s2_q_r} * {12'd0, jbct_pkg::TEN_K};

  always_ff @(posedge clk) begin
    if (s3_go) begin
      s3_rem_r  <= s2_mag_lo_r - q_times_10k[13:0];
      s3_zero_r <= s2_zero_r;
      s3_neg_r  <= s2_neg_r;
      s3_has_r  <= s2_has_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 3 -> 4: digits from independent reciprocal quotients.
  logic [28:0] p10, p100, p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] q10_x10;
  logic [9:0]  q100_x10;
  logic [6:0]  q1000_x10;

  assign p10   = {15'd0, s3_rem_r} * {14'd0, jbct_pkg::MUL_10};
  assign p100  = {15'd0, s3_rem_r} * {14'd0, jbct_pkg::MUL_100};
  assign p1000 = {15'd0, s3_rem_r} * {14'd0, jbct_pkg::MUL_1000};
  assign q10   = p10[27:18];
  assign q100  = p100[27:21];
  assign q1000 = p1000[27:24];
  assign q10_x10   = {q10, 3'd0} + {3'd0, q10, 1'b0};
  assign q100_x10  = {q100, 3'd0} + {2'd0, q100, 1'b0};
  assign q1000_x10 = {q1000, 3'd0} + {2'd0, q1000, 1'b0};

  always_ff @(posedge clk) begin
    if (s4_go) begin
      s4_d0_r   <= s3_rem_r[3:0] - q10_x10[3:0];
      s4_d1_r   <= q10[3:0] - q100_x10[3:0];
      s4_d2_r   <= q100[3:0] - q1000_x10[3:0];
      s4_d3_r   <= q1000;
      s4_zero_r <= s3_zero_r;
      s4_neg_r  <= s3_neg_r;
      s4_has_r  <= s3_has_r;
      s4_last_r <= s3_last_r;
    end
  end

  // Stage 4: decode, saturating accumulate and result formation.
  jbct_pkg::decode_t dec;
  logic signed [SW:0]  sum_ext;
  logic signed [SW-1:0] sum_acc;
  logic                 err_acc;
  logic signed [32:0]   sum_wide;
  logic signed [jbct_pkg::NET_W-1:0] net_shown;

  localparam logic signed [SW:0] SMAX = (SW+1)'((64'sd1 <<< (SW-1)) - 1);
  localparam logic signed [SW:0] SMIN = -SMAX - 1;

  assign dec = jbct_pkg::decode_b(s4_d3_r, s4_d2_r, s4_d1_r, s4_d0_r, s4_zero_r, s4_neg_r);

  always_comb begin
    sum_ext = {sum_r[SW-1], sum_r} + (SW+1)'(dec.contrib);
    if (!s4_has_r) begin
      sum_acc = sum_r;
      err_acc = err_r;
    end else begin
      if (sum_ext > SMAX) begin
        sum_acc = SMAX[SW-1:0];
      end else if (sum_ext < SMIN) begin
        sum_acc = SMIN[SW-1:0];
      end else begin
        sum_acc = sum_ext[SW-1:0];
      end
      err_acc = err_r | dec.bad;
    end

    // Clamp the jet total to the width of the result field.
    sum_wide = 33'(sum_acc);
    if (sum_wide > 33'sd2047) begin
      net_shown = 12'sd2047;
    end else if (sum_wide < -33'sd2048) begin
      net_shown = -12'sd2048;
    end else begin
      net_shown = sum_wide[jbct_pkg::NET_W-1:0];
    end
  end

  always_comb begin
    sum_nxt       = sum_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s4_v_r && s4_ok) begin
      if (s4_last_r) begin
        sum_nxt       = '0;
        err_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = sum_acc;
        err_nxt = err_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v_r && s4_ok && s4_last_r) begin
      out_tagged_r <= (sum_acc != '0);
      out_weight_r <= (sum_acc != '0) ? tag_prob_r : fake_prob_r;
      out_net_r    <= net_shown;
      out_error_r  <= err_acc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_weight      = out_weight_r;
  assign out_tagged_res  = out_tagged_r;
  assign out_net_b_total = out_net_r;
  assign out_code_error  = out_error_r;

endmodule

// File: tb/tb.sv
// Self-checking testbench for jet_b_content_tagger_unit: directed and random jets,
// checked against a built-in net b count predictor with valid/ready idling.
// Depends on jbct_pkg and jet_b_content_tagger_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for a constituent without a result to leave the decode
  // pipeline before a register write.
  localparam int PIPE_DRAIN = 10;
  // Length of the long result hold-off that backs the pipeline up.
  localparam int LONG_HOLD  = 300;

  // One jet result as the block should report it.
  typedef struct {
    logic [jbct_pkg::WEIGHT_W-1:0]     weight;
    logic                              tag_hit;
    logic signed [jbct_pkg::NET_W-1:0] net_b;
    logic                              code_err;
  } jet_tag_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [jbct_pkg::CODE_W-1:0]  in_particle_code;
  logic                                in_has_identity;
  logic                                in_last_in_jet;
  logic                                out_valid;
  logic                                out_ready;
  logic [jbct_pkg::WEIGHT_W-1:0]       out_weight;
  logic                                out_tagged_res;
  logic signed [jbct_pkg::NET_W-1:0]   out_net_b_total;
  logic                                out_code_error;
  logic                                cfg_we;
  logic [jbct_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [jbct_pkg::WEIGHT_W-1:0]       cfg_wdata;

  // Predictor state: the configured weights and the jet being accumulated.
  logic [jbct_pkg::WEIGHT_W-1:0] tag_weight;
  logic [jbct_pkg::WEIGHT_W-1:0] fake_weight;
  longint                        jet_b_sum;
  bit                            jet_code_err;

  // Jet results that the block still owes, oldest first.
  jet_tag_t pending_tags[$];

  int failures = 0;
  bit quiet_mode;      // When set, neither side idles.
  int long_hold_reqs;  // Count of long hold-offs asked of the result side.

  jet_b_content_tagger_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_particle_code (in_particle_code),
    .in_has_identity  (in_has_identity),
    .in_last_in_jet   (in_last_in_jet),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_weight       (out_weight),
    .out_tagged_res   (out_tagged_res),
    .out_net_b_total  (out_net_b_total),
    .out_code_error   (out_code_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A fixed watchdog far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Net b minus anti-b count of one particle code. The low four decimal
  // digits of the magnitude are split out; the position of the highest
  // nonzero digit picks the particle class. An unreadable code flags bad
  // and contributes nothing.
  function automatic void decode_b_count(input int code, output int delta, output bit bad);
    int mag;
    int sgn;
    int top;
    int k;
    int dg[4];
    delta = 0;
    bad   = 1'b0;
    if (code == 0) return;
    sgn = (code > 0) ? 1 : -1;
    mag = (code > 0) ? code : -code;
    top = 0;
    for (k = 0; k < 4; k++) begin
      dg[k] = mag % 10;
      if (dg[k] != 0) top = k + 1;
      mag = mag / 10;
    end
    case (top)
      0: bad = 1'b1;  // nonzero code with nothing in the low four digits
      1: begin
        if (dg[0] > 6) bad = 1'b1;
        else if (dg[0] == 5) delta = sgn;
      end
      2: ;            // leptons carry no b
      default: begin
        for (k = 1; k < top; k++)
          if (dg[k] > 6) bad = 1'b1;
        if (!bad) begin
          if (top == 4) begin
            // Baryon or diquark: each 5 among the quark digits counts.
            for (k = 1; k < 4; k++)
              if (dg[k] == 5) delta += sgn;
          end else begin
            // Meson: the leading quark of a down-type flavor is the antiquark.
            if (dg[2] == 3 || dg[2] == 5) sgn = -sgn;
            if (dg[2] == 5) delta += sgn;
            if (dg[1] == 5) delta -= sgn;
          end
        end
      end
    endcase
  endfunction

  // Folds one accepted constituent into the jet and, at the end of the jet,
  // queues the result that the block must produce.
  function automatic void absorb_constituent(input logic signed [jbct_pkg::CODE_W-1:0] code,
                                             input logic has_id, input logic last);
    int       delta;
    bit       bad;
    longint   sum_max;
    longint   sum_min;
    longint   acc;
    longint   shown;
    jet_tag_t tag;
    sum_max = (longint'(1) <<< (jbct_pkg::SUM_W - 1)) - 1;
    sum_min = -sum_max - 1;
    if (has_id) begin
      decode_b_count(int'(code), delta, bad);
      if (bad) jet_code_err = 1'b1;
      acc = jet_b_sum + delta;
      if (acc > sum_max) acc = sum_max;
      if (acc < sum_min) acc = sum_min;
      jet_b_sum = acc;
    end
    if (last) begin
      shown = jet_b_sum;
      if (shown > 2047) shown = 2047;
      if (shown < -2048) shown = -2048;
      tag.tag_hit  = (jet_b_sum != 0);
      tag.weight   = tag.tag_hit ? tag_weight : fake_weight;
      tag.net_b    = shown[jbct_pkg::NET_W-1:0];
      tag.code_err = jet_code_err;
      pending_tags.insert(pending_tags.size(), tag);
      jet_b_sum    = 0;
      jet_code_err = 1'b0;
    end
  endfunction

  // Offers one constituent and returns right after the edge that takes it.
  // Every call starts at the next falling edge, so valid either carries the
  // next constituent straight on or drops for an idle burst.
  task automatic send_constituent(input int code, input bit has_id, input bit last);
    @(negedge clk);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_particle_code <= code[jbct_pkg::CODE_W-1:0];
    in_has_identity  <= has_id;
    in_last_in_jet   <= last;
    do @(posedge clk); while (!in_ready);
    absorb_constituent(code[jbct_pkg::CODE_W-1:0], has_id, last);
  endtask

  // Drops valid and waits until every result is in and the pipeline is empty.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // Writes both weight registers while the block is idle.
  task automatic write_weights(input logic [jbct_pkg::WEIGHT_W-1:0] tag_w,
                               input logic [jbct_pkg::WEIGHT_W-1:0] fake_w);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= jbct_pkg::CFG_TAG_PROB;
    cfg_wdata <= tag_w;
    @(negedge clk);
    cfg_index <= jbct_pkg::CFG_FAKE_PROB;
    cfg_wdata <= fake_w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tag_weight  = tag_w;
    fake_weight = fake_w;
  endtask

  // A random weight over the full register range.
  function automatic logic [jbct_pkg::WEIGHT_W-1:0] rand_weight();
    logic [31:0] rnd;
    rnd = $urandom;
    return rnd[jbct_pkg::WEIGHT_W-1:0];
  endfunction

  // Builds a particle code from a mix of particle classes: b hadrons, light
  // hadrons, lone quarks, leptons, unreadable codes and raw noise. Upper
  // digits beyond the low four are added now and then, and the sign is random.
  function automatic int pick_code();
    int d3;
    int d2;
    int d1;
    int d0;
    int mag;
    logic [31:0] rnd;
    logic signed [jbct_pkg::CODE_W-1:0] raw;
    d3 = 0;
    d2 = 0;
    d1 = 0;
    d0 = $urandom_range(1, 9);
    case ($urandom_range(0, 11))
      0, 1: begin
        d2 = 5;
        d1 = $urandom_range(0, 6);
      end
      2: begin
        d2 = $urandom_range(1, 6);
        d1 = $urandom_range(1, 6);
      end
      3: begin
        d3 = $urandom_range(1, 6);
        d2 = $urandom_range(0, 6);
        d1 = $urandom_range(0, 6);
      end
      4: begin
        d3 = 5;
        d2 = $urandom_range(4, 5);
        d1 = $urandom_range(4, 5);
      end
      5: d0 = $urandom_range(1, 9);
      6: d1 = $urandom_range(1, 9);
      7: begin
        if ($urandom_range(0, 1)) begin
          d3 = $urandom_range(7, 9);
        end else begin
          d2 = $urandom_range(7, 9);
          d1 = $urandom_range(0, 9);
        end
      end
      8: d0 = 0;
      9: return int'($urandom_range(0, 19999998)) - 9999999;
      default: begin
        rnd = $urandom;
        raw = rnd[jbct_pkg::CODE_W-1:0];
        return int'(raw);
      end
    endcase
    mag = d3 * 1000 + d2 * 100 + d1 * 10 + d0;
    if ($urandom_range(0, 3) == 0) mag += $urandom_range(0, 999) * 10000;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Result side: short random stalls, plus the long hold-off on request,
  // counted here in cycles.
  initial begin : result_sink
    int hold_cycles;
    int holds_served;
    hold_cycles  = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles == 0 && holds_served != long_hold_reqs) begin
        hold_cycles = LONG_HOLD;
        holds_served++;
      end else if (hold_cycles == 0 && !quiet_mode && $urandom_range(0, 5) == 0) begin
        hold_cycles = $urandom_range(1, 3);
      end
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each result transfer is compared with the oldest jet still owed.
  always @(posedge clk) begin : result_check
    jet_tag_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tags.size() == 0) begin
        $display("%0t: result with no jet pending: weight %0d tagged %0d net %0d err %0d",
                 $time, out_weight, out_tagged_res, out_net_b_total, out_code_error);
        failures++;
      end else begin
        want = pending_tags.pop_front();
        if (out_weight !== want.weight) begin
          $display("%0t: weight expected %0d actual %0d", $time, want.weight, out_weight);
          failures++;
        end
        if (out_tagged_res !== want.tag_hit) begin
          $display("%0t: tagged expected %0d actual %0d", $time, want.tag_hit,
                   out_tagged_res);
          failures++;
        end
        if (out_net_b_total !== want.net_b) begin
          $display("%0t: net b expected %0d actual %0d", $time, want.net_b,
                   out_net_b_total);
          failures++;
        end
        if (out_code_error !== want.code_err) begin
          $display("%0t: code error expected %0d actual %0d", $time, want.code_err,
                   out_code_error);
          failures++;
        end
      end
    end
  end

  // Weights straight out of reset must both read zero.
  task automatic test_reset_weights();
    send_constituent(511, 1'b1, 1'b1);
    send_constituent(0, 1'b1, 1'b1);
  endtask

  // One jet per code, so each contribution shows on its own, then a few
  // multi-constituent jets for the sticky error flag.
  task automatic test_directed_codes();
    write_weights(16'hFFFF, 16'h0000);
    send_constituent(0, 1'b1, 1'b1);           // zero code
    send_constituent(5, 1'b1, 1'b1);           // lone b quark
    send_constituent(-5, 1'b1, 1'b1);          // lone anti-b
    send_constituent(6, 1'b1, 1'b1);           // lone top, no b
    send_constituent(7, 1'b1, 1'b1);           // lone digit above six
    send_constituent(11, 1'b1, 1'b1);          // lepton
    send_constituent(-13, 1'b1, 1'b1);
    send_constituent(511, 1'b1, 1'b1);         // neutral B, sign flipped
    send_constituent(-511, 1'b1, 1'b1);
    send_constituent(521, 1'b1, 1'b1);         // charged B, sign flipped
    send_constituent(531, 1'b1, 1'b1);
    send_constituent(553, 1'b1, 1'b1);         // bottomonium nets out
    send_constituent(5122, 1'b1, 1'b1);        // b baryon
    send_constituent(-5554, 1'b1, 1'b1);       // three anti-b
    send_constituent(10000, 1'b1, 1'b1);       // low four digits all zero
    send_constituent(581, 1'b1, 1'b1);         // meson digit above six
    send_constituent(7122, 1'b1, 1'b1);        // baryon digit above six
    send_constituent(16777215, 1'b1, 1'b1);    // most positive code
    send_constituent(-16777216, 1'b1, 1'b1);   // most negative code
    send_constituent(5, 1'b0, 1'b1);           // code without identity
    // The error flag holds over the jet and clears after its result.
    send_constituent(7, 1'b1, 1'b0);
    send_constituent(511, 1'b1, 1'b1);
    send_constituent(-521, 1'b1, 1'b0);
    send_constituent(5, 1'b1, 1'b1);
    write_weights(16'h0000, 16'hFFFF);
    send_constituent(5, 1'b1, 1'b1);
    send_constituent(11, 1'b1, 1'b1);
  endtask

  // Long jets that drive the sum past both limits and step back from them.
  task automatic test_saturation();
    write_weights(16'h8001, 16'h7FFE);
    repeat (690) send_constituent(5555, 1'b1, 1'b0);
    send_constituent(-5, 1'b1, 1'b1);
    repeat (690) send_constituent(-5555, 1'b1, 1'b0);
    send_constituent(5, 1'b1, 1'b1);
  endtask

  // The result side holds off for a long stretch while jets keep coming, so
  // the pipeline fills and input ready drops.
  task automatic test_backpressure();
    write_weights(16'h1234, 16'hFEDC);
    long_hold_reqs++;
    repeat (40) send_constituent($urandom_range(0, 1) ? 521 : -5122, 1'b1, 1'b1);
  endtask

  // Random jets under several weight settings; the last phase runs without
  // idling on either side.
  task automatic test_random_jets();
    int phase;
    int sent;
    int jet_len;
    int k;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_weights(rand_weight(), rand_weight());
        1: write_weights(16'hFFFF, 16'hFFFF);
        2: write_weights(16'h0000, 16'h0000);
        3: write_weights(rand_weight(), 16'hFFFF);
        default: write_weights(16'h0001, rand_weight());
      endcase
      quiet_mode = (phase == 4);
      sent = 0;
      while (sent < 24) begin
        jet_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (k = 0; k < jet_len; k++)
          send_constituent(pick_code(), $urandom_range(0, 9) != 0, k == jet_len - 1);
        sent += jet_len;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_particle_code = '0;
    in_has_identity  = 1'b0;
    in_last_in_jet   = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = jbct_pkg::CFG_TAG_PROB;
    cfg_wdata        = '0;
    tag_weight       = '0;
    fake_weight      = '0;
    jet_b_sum        = 0;
    jet_code_err     = 1'b0;
    quiet_mode       = 1'b0;
    long_hold_reqs   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_weights();
    test_directed_codes();
    test_saturation();
    test_backpressure();
    test_random_jets();

    drain_block();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/jbct_pkg.sv
src/jet_b_content_tagger_unit.sv
tb/tb.sv
